// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Field widths, operation and status codes, and the entry and control types
// that pass between the top level and the row of storage cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int PRIO_W          = 8;
    localparam int STATUS_W        = 2;
    localparam int OCC_W           = 5;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one storage slot of the sorted priority queue
// Holds one entry. On an insert it keeps its entry, takes the new entry or
// takes its left neighbor's entry; on a removal it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               valid,
    input  spq_pkg::entry_t    left_data,
    input  logic               left_ins,
    input  spq_pkg::entry_t    right_data,
    output spq_pkg::entry_t    data,
    output logic               ins
);
    import spq_pkg::*;

    entry_t data_reg;
    entry_t data_next;

    // A slot lies at or behind the insertion point when it is empty or its
    // priority number is strictly greater than the new one.
    assign ins = !valid || (data_reg.prio > ctrl.new_entry.prio);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.enq && ins)
        begin
            data_next = left_ins ? left_data : ctrl.new_entry;
        end
        else if (ctrl.deq)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in sorted order
// An item is accepted on any edge where start is high, busy is never raised,
// and the result appears with done in the following cycle. The row of cells
// compares and shifts all slots in parallel, so an enqueue or dequeue may be
// issued every cycle. The result strobe cannot be stalled; the receiver must
// take each transfer as it comes.
// Enqueue places the entry ahead of the first greater priority number, equal
// priorities stay first-in, first-out; a full queue drops and flags it.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic signed [spq_pkg::VALUE_W-1:0] value_in,
    input  logic [spq_pkg::PRIO_W-1:0]         priority_in,
    output logic                               done,
    output logic [spq_pkg::STATUS_W-1:0]       status,
    output logic signed [spq_pkg::VALUE_W-1:0] value_out,
    output logic [spq_pkg::PRIO_W-1:0]         priority_out,
    output logic [spq_pkg::OCC_W-1:0]          occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    status_t          status_reg;
    status_t          status_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [OCC_W-1:0]  occ_reg;

    logic       accept;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;

    entry_t cell_data [QUEUE_DEPTH];
    logic   cell_ins  [QUEUE_DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        ctrl.enq             = accept && (func == FUNC_ENQ) && !full;
        ctrl.deq             = accept && (func == FUNC_DEQ) && !empty;
        ctrl.new_entry.value = value_in;
        ctrl.new_entry.prio  = priority_in;

        count_next  = count_reg;
        status_next = ST_OK;
        value_next  = '0;
        prio_next   = '0;
        if (func == FUNC_ENQ)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
                value_next = cell_data[0].value;
                prio_next  = cell_data[0].prio;
            end
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_data;
        logic   left_ins;
        entry_t right_data;
        logic   valid;

        assign valid = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_data = '0;
            assign left_ins  = 1'b0;
        end
        else
        begin : g_body
            assign left_data = cell_data[i-1];
            assign left_ins  = cell_ins[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner
            assign right_data = cell_data[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (valid),
            .left_data  (left_data),
            .left_ins   (left_ins),
            .right_data (right_data),
            .data       (cell_data[i]),
            .ins        (cell_ins[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            prio_reg   <= prio_next;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign value_out    = value_reg;
    assign priority_out = prio_reg;
    assign occupancy    = occ_reg;

    a_done_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> done
    ) else $error("result transfer missing after accepted item");

    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH)
    ) else $error("entry count exceeds queue depth");

    a_full_flag_consistent: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_ENQ) && full |=> (status == ST_FULL) && $stable(count_reg)
    ) else $error("enqueue on full queue not dropped");

    a_dequeue_decrements: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_DEQ) && !empty |=> count_reg == $past(count_reg) - CNT_W'(1)
    ) else $error("dequeue did not remove one entry");

endmodule

// ===== dv/sorted_priority_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// Drives enqueue and dequeue commands through the start/busy handshake and
// keeps its own sorted copy of the queue to predict every result. Each done
// strobe is compared field by field with the oldest prediction. A directed
// part covers the empty, full, tie and extreme-value cases. Random traffic
// then swings the queue between empty and full under several sender idle rates.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;

    typedef struct {
        status_t                    status;
        logic signed [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]          prio;
        logic [OCC_W-1:0]           occupancy;
    } op_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       func;
    logic signed [VALUE_W-1:0]  value_in;
    logic [PRIO_W-1:0]          priority_in;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  value_out;
    logic [PRIO_W-1:0]          priority_out;
    logic [OCC_W-1:0]           occupancy;

    logic signed [VALUE_W-1:0]  held_value[QUEUE_DEPTH];
    logic [PRIO_W-1:0]          held_prio[QUEUE_DEPTH];
    int                         held_count;
    op_result_t                 expected_results[$];

    int sender_idle_pct;
    int mismatch_count;
    int stray_count;
    int enq_count;
    int deq_count;
    int full_drop_count;
    int empty_deq_count;

    sorted_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .value_in     (value_in),
        .priority_in  (priority_in),
        .done         (done),
        .status       (status),
        .value_out    (value_out),
        .priority_out (priority_out),
        .occupancy    (occupancy)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_operation(input logic op, input logic signed [VALUE_W-1:0] val,
                                     input logic [PRIO_W-1:0] prio);
        op_result_t res;
        int         slot;
        int         k;
        res.status = ST_OK;
        res.value  = '0;
        res.prio   = '0;
        if (op == FUNC_ENQ)
        begin
            enq_count++;
            if (held_count >= QUEUE_DEPTH)
            begin
                res.status = ST_FULL;
                full_drop_count++;
            end
            else
            begin
                slot = held_count;
                for (k = held_count - 1; k >= 0; k--)
                begin
                    if (held_prio[k] > prio)
                        slot = k;
                end
                for (k = held_count; k > slot; k--)
                begin
                    held_value[k] = held_value[k - 1];
                    held_prio[k]  = held_prio[k - 1];
                end
                held_value[slot] = val;
                held_prio[slot]  = prio;
                held_count++;
            end
        end
        else
        begin
            deq_count++;
            if (held_count == 0)
            begin
                res.status = ST_EMPTY;
                empty_deq_count++;
            end
            else
            begin
                res.value = held_value[0];
                res.prio  = held_prio[0];
                for (k = 1; k < held_count; k++)
                begin
                    held_value[k - 1] = held_value[k];
                    held_prio[k - 1]  = held_prio[k];
                end
                held_count--;
            end
        end
        res.occupancy = held_count[OCC_W-1:0];
        expected_results.push_back(res);
    endtask

    // Predictions are queued before the check so that the order holds for any latency.
    always @(posedge clk)
    begin
        op_result_t exp_res;
        if (rst_n)
        begin
            if (start && !busy)
                predict_operation(func, value_in, priority_in);
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    stray_count++;
                    $display("ERROR: result transfer with no operation outstanding");
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (status !== exp_res.status || value_out !== exp_res.value ||
                        priority_out !== exp_res.prio || occupancy !== exp_res.occupancy)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"MISMATCH: expected status %0d value %0d prio %0d ",
                                      "occ %0d, got status %0d value %0d prio %0d occ %0d"},
                                     exp_res.status, exp_res.value, exp_res.prio,
                                     exp_res.occupancy, status, value_out, priority_out,
                                     occupancy);
                    end
                end
            end
        end
    end

    task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] val,
                             input logic [PRIO_W-1:0] prio);
        start       = 1'b1;
        func        = op;
        value_in    = val;
        priority_in = prio;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start = 1'b0;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            func        = 1'($urandom_range(1));
            value_in    = $urandom;
            priority_in = PRIO_W'($urandom_range(255));
            @(negedge clk);
        end
    endtask

    task automatic wait_results_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_empty_dequeue();
        send_item(FUNC_DEQ, 32'sd0, 8'd0);
        send_item(FUNC_DEQ, -32'sd1, 8'hFF);
    endtask

    task automatic test_fill_and_overflow();
        int k;
        send_item(FUNC_ENQ, 32'sh7FFF_FFFF, 8'd255);
        send_item(FUNC_ENQ, 32'sh8000_0000, 8'd0);
        send_item(FUNC_ENQ, -32'sd1, 8'd128);
        send_item(FUNC_ENQ, 32'sd0, 8'd128);
        send_item(FUNC_ENQ, 32'sd1, 8'd128);
        send_item(FUNC_ENQ, 32'sh5555_5555, 8'h55);
        send_item(FUNC_ENQ, 32'shAAAA_AAAA, 8'hAA);
        send_item(FUNC_ENQ, 32'sh1234_5678, 8'd0);
        for (k = 0; k < QUEUE_DEPTH - 8; k++)
            send_item(FUNC_ENQ, $urandom, PRIO_W'($urandom_range(255)));
        send_item(FUNC_ENQ, 32'sh0BAD_F00D, 8'd0);
    endtask

    task automatic test_priority_order();
        int k;
        for (k = 0; k < 4; k++)
            send_item(FUNC_DEQ, 32'sd0, 8'd0);
        send_item(FUNC_ENQ, -32'sd12345, 8'd0);
        send_item(FUNC_DEQ, 32'sd0, 8'd0);
    endtask

    task automatic test_random_traffic(input int item_total, input int idle_pct);
        logic filling;
        logic op;
        int   k;
        sender_idle_pct = idle_pct;
        filling = 1'b1;
        for (k = 0; k < item_total; k++)
        begin
            if (held_count == QUEUE_DEPTH && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (held_count == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            if (filling)
                op = ($urandom_range(99) < 75) ? FUNC_ENQ : FUNC_DEQ;
            else
                op = ($urandom_range(99) < 25) ? FUNC_ENQ : FUNC_DEQ;
            send_item(op, $urandom,
                      PRIO_W'($urandom_range(1) ? $urandom_range(3) : $urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        func            = FUNC_ENQ;
        value_in        = '0;
        priority_in     = '0;
        held_count      = 0;
        sender_idle_pct = 0;
        mismatch_count  = 0;
        stray_count     = 0;
        enq_count       = 0;
        deq_count       = 0;
        full_drop_count = 0;
        empty_deq_count = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_dequeue();
        test_fill_and_overflow();
        test_priority_order();
        wait_results_drained();
        test_random_traffic(200, 17);
        wait_results_drained();
        test_random_traffic(200, 57);
        wait_results_drained();
        test_random_traffic(200, 0);
        wait_results_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d enqueues (%0d dropped on a full queue) and %0d dequeues",
                 enq_count, full_drop_count, deq_count);
        $display("(%0d on an empty queue) at sender idle rates of 17, 57 and 0 percent.",
                 empty_deq_count);
        if (mismatch_count == 0 && stray_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Timeout with %0d results outstanding.", expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
